FILE: sv/prec_pkg.sv
// shared constants, types and the rule table of the pressure rule engine
`default_nettype none
package prec_pkg;

	// rule passes before the state vector is given up as not converging
	localparam int MAX_PASSES = 16;
	localparam int PASS_W = (MAX_PASSES > 2) ? $clog2(MAX_PASSES) : 1;
	localparam int RULE_COUNT = 13;

	// field widths
	localparam int IN_W = 24;
	localparam int ST_W = 18;
	localparam int PD_W = 25;
	localparam int MAG_W = 24;
	localparam int SD_W = 19;
	localparam int SV_W = 16;
	localparam int COND_W = 10;
	localparam int ACT_W = 6;
	localparam int ACT_LSB = 10;
	localparam int SSP_W = 18;
	localparam int PSP_W = 24;
	localparam int TOL_W = 16;
	localparam int MAXF_W = 17;
	localparam int GAIN_W = 16;
	localparam int RELOAD_W = 20;
	localparam int CMP_W = 19;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 64;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_STATIC_SP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITOT_SP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FMAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd4;

	// divide by 100 as multiply by reciprocal, exact for 24 bit inputs
	localparam int DIV100_MUL_W = 26;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 26'd42949673;
	localparam int DIV100_SH = 32;
	localparam int DIV100_PROD_W = IN_W + DIV100_MUL_W;

	// divide by 20 as multiply by reciprocal, exact for 17 bit inputs
	localparam int DIV20_MUL_W = 18;
	localparam logic [DIV20_MUL_W-1:0] DIV20_MUL = 18'd209716;
	localparam int DIV20_SH = 22;
	localparam int DIV20_PROD_W = MAXF_W + DIV20_MUL_W;
	localparam int MIN_F_W = DIV20_PROD_W - DIV20_SH;

	// near atmosphere threshold is ambient / 16
	localparam int ATM_SH = 4;

	// stepper frequency products
	localparam int GAIN_SH = 8;
	localparam int PROD1_W = MAXF_W + GAIN_W;
	localparam int PROD2_W = PROD1_W + MAG_W;
	localparam int FREQ_W = PROD2_W - GAIN_SH;
	localparam logic [RELOAD_W-1:0] RELOAD_NUM = 20'd1000000;
	localparam int DIV_CNT_W = $clog2(RELOAD_W);

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 2) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// state vector bit positions
	localparam int B_OK = 0;
	localparam int B_EXV = 10;
	localparam int B_DFV = 11;
	localparam int B_VAC = 12;
	localparam int B_STP = 13;
	localparam int B_DIR = 14;
	localparam int B_PRP = 15;

	localparam logic [SV_W-1:0] M_NONE = 16'h0000;
	localparam logic [SV_W-1:0] M_OK = 16'h0001;
	localparam logic [SV_W-1:0] M_SLO = 16'h0002;
	localparam logic [SV_W-1:0] M_SLT = 16'h0004;
	localparam logic [SV_W-1:0] M_SHT = 16'h0008;
	localparam logic [SV_W-1:0] M_SHI = 16'h0010;
	localparam logic [SV_W-1:0] M_PLO = 16'h0020;
	localparam logic [SV_W-1:0] M_PLT = 16'h0040;
	localparam logic [SV_W-1:0] M_PHT = 16'h0080;
	localparam logic [SV_W-1:0] M_PHI = 16'h0100;
	localparam logic [SV_W-1:0] M_ATM = 16'h0200;
	localparam logic [SV_W-1:0] M_EXV = 16'h0400;
	localparam logic [SV_W-1:0] M_DFV = 16'h0800;
	localparam logic [SV_W-1:0] M_VAC = 16'h1000;
	localparam logic [SV_W-1:0] M_STP = 16'h2000;
	localparam logic [SV_W-1:0] M_DIR = 16'h4000;
	localparam logic [SV_W-1:0] M_PRP = 16'h8000;

	typedef struct packed {
		logic [SV_W-1:0] need_clr;
		logic [SV_W-1:0] need_set;
		logic [SV_W-1:0] do_clr;
		logic [SV_W-1:0] do_set;
	} rule_t;

	localparam rule_t RULES [RULE_COUNT] = '{
		'{M_OK, M_NONE, M_VAC | M_STP | M_PRP, M_NONE},
		'{M_NONE, M_OK | M_SLO, M_VAC, M_EXV | M_DFV},
		'{M_NONE, M_OK | M_SLT, M_VAC, M_NONE},
		'{M_NONE, M_OK | M_SHT, M_EXV, M_NONE},
		'{M_NONE, M_OK | M_SHI, M_EXV, M_VAC | M_DFV},
		'{M_NONE, M_OK | M_PLO, M_NONE, M_DIR | M_STP | M_DFV},
		'{M_DIR, M_OK | M_PLT, M_STP, M_NONE},
		'{M_NONE, M_OK | M_PHT | M_DIR, M_STP, M_NONE},
		'{M_NONE, M_OK | M_PHI, M_DIR, M_STP | M_DFV},
		'{M_NONE, M_OK | M_ATM | M_DFV, M_NONE, M_PRP},
		'{M_ATM, M_NONE, M_PRP, M_NONE},
		'{M_DFV, M_NONE, M_PRP, M_NONE},
		'{M_STP | M_VAC | M_EXV, M_NONE, M_DFV, M_NONE}
	};

	typedef struct packed {
		logic [SSP_W-1:0] static_sp;
		logic [PSP_W-1:0] pitot_sp;
		logic [TOL_W-1:0] tol;
		logic [MAXF_W-1:0] fmax;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

	// classified item: condition bits 0..9 of the state vector and |pitot delta|
	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [MAG_W-1:0] mag;
	} q_entry_t;

	// one pass over the rule table, rules applied in order
	function automatic logic [SV_W-1:0] rule_pass(input logic [SV_W-1:0] v_in);
		logic [SV_W-1:0] v;
		v = v_in;
		for (int i = 0; i < RULE_COUNT; i++) begin
			if (((v & RULES[i].need_set) == RULES[i].need_set) &&
					((v & RULES[i].need_clr) == M_NONE)) begin
				v = (v & ~RULES[i].do_clr) | RULES[i].do_set;
			end
		end
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: sv/prec_front.sv
// front end: takes requests, scales the readings and classifies them into condition bits
`default_nettype none
module prec_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire prec_pkg::cfg_t                  cfg,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// static raw, ambient raw, pitot, sensors ok, zero fill
	input  wire logic [prec_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	output logic                                 push_valid,
	input  wire logic                            push_ready,
	output prec_pkg::q_entry_t                   push_data
);

	localparam int BAND_W = 26;
	localparam int IN_W = prec_pkg::IN_W;
	localparam int ST_W = prec_pkg::ST_W;
	localparam int PD_W = prec_pkg::PD_W;
	localparam int SD_W = prec_pkg::SD_W;
	localparam int TOL_W = prec_pkg::TOL_W;
	localparam int PROD_W = prec_pkg::DIV100_PROD_W;
	localparam int SH = prec_pkg::DIV100_SH;

	logic valid_s1, valid_s2;
	logic adv_s1, adv_s2;

	logic [IN_W-1:0] st_raw_s1, atm_raw_s1, pit_s1;
	logic ok_s1;

	logic [ST_W-1:0] st_s2, atm_s2;
	logic signed [PD_W-1:0] pd_s2;
	logic ok_s2;

	logic [PROD_W-1:0] st_prod, atm_prod;
	logic signed [PD_W-1:0] pd_s1;

	logic signed [SD_W-1:0] sd, atm_diff, atm_thr;
	logic signed [PD_W-1:0] pd_neg;
	logic [3:0] sband, pband;
	logic near_atm;

	// lt, lt-in-tol, gt-in-tol, gt in bits 0..3, all strict
	function automatic logic [3:0] band_bits(input logic signed [BAND_W-1:0] d,
			input logic [TOL_W-1:0] tol);
		logic signed [BAND_W-1:0] ptol, ntol;
		logic [3:0] r;
		ptol = {{(BAND_W-TOL_W){1'b0}}, tol};
		ntol = -ptol;
		r[0] = d < ntol;
		r[1] = (d < 0) && (d > ntol);
		r[2] = (d > 0) && (d < ptol);
		r[3] = d > ptol;
		return r;
	endfunction

	assign adv_s2 = !valid_s2 || push_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			st_raw_s1 <= s_axis_tdata[IN_W-1:0];
			atm_raw_s1 <= s_axis_tdata[2*IN_W-1:IN_W];
			pit_s1 <= s_axis_tdata[3*IN_W-1:2*IN_W];
			ok_s1 <= s_axis_tdata[3*IN_W];
		end
	end

	// divide by 100 through the reciprocal, pitot delta
	always_comb begin
		st_prod = PROD_W'(st_raw_s1) * PROD_W'(prec_pkg::DIV100_MUL);
		atm_prod = PROD_W'(atm_raw_s1) * PROD_W'(prec_pkg::DIV100_MUL);
		pd_s1 = $signed({pit_s1[IN_W-1], pit_s1}) -
			$signed({cfg.pitot_sp[prec_pkg::PSP_W-1], cfg.pitot_sp});
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			st_s2 <= st_prod[SH+ST_W-1:SH];
			atm_s2 <= atm_prod[SH+ST_W-1:SH];
			pd_s2 <= pd_s1;
			ok_s2 <= ok_s1;
		end
	end

	always_comb begin
		sd = $signed({1'b0, st_s2}) - $signed({1'b0, cfg.static_sp});
		sband = band_bits({{(BAND_W-SD_W){sd[SD_W-1]}}, sd}, cfg.tol);
		pband = band_bits({{(BAND_W-PD_W){pd_s2[PD_W-1]}}, pd_s2}, cfg.tol);
		atm_diff = $signed({1'b0, atm_s2}) - $signed({1'b0, st_s2});
		atm_thr = $signed({{(prec_pkg::ATM_SH+1){1'b0}}, atm_s2[ST_W-1:prec_pkg::ATM_SH]});
		near_atm = atm_diff < atm_thr;
		pd_neg = -pd_s2;
		push_data.cond = {near_atm, pband, sband, ok_s2};
		push_data.mag = pd_s2[PD_W-1] ? pd_neg[prec_pkg::MAG_W-1:0] :
			pd_s2[prec_pkg::MAG_W-1:0];
	end

	assign push_valid = valid_s2;

endmodule
`default_nettype wire

FILE: sv/prec_queue.sv
// short queue of classified requests between front and back
`default_nettype none
module prec_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_ready,
	input  wire prec_pkg::q_entry_t  push_data,
	output logic                     pop_valid,
	input  wire logic                pop_ready,
	output prec_pkg::q_entry_t       pop_data
);

	localparam int QDEPTH = prec_pkg::QDEPTH;
	localparam int QPTR_W = prec_pkg::QPTR_W;
	localparam int QCNT_W = prec_pkg::QCNT_W;

	prec_pkg::q_entry_t entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push, do_pop;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign pop_valid = count_q != '0;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

FILE: sv/prec_back.sv
// back end: rule passes to a fixed point or the pass limit, stepper frequency and serial reload divider
`default_nettype none
module prec_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire prec_pkg::cfg_t                  cfg,
	input  wire logic                            pop_valid,
	output logic                                 pop_ready,
	input  wire prec_pkg::q_entry_t              pop_data,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// state vector, exhaust, diff valve, vacuum pump, pressure pump, stepper on,
	// stepper dir, reload, compare, not converged, zero fill
	output logic [prec_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

	localparam int SV_W = prec_pkg::SV_W;
	localparam int PASS_W = prec_pkg::PASS_W;
	localparam int MAXF_W = prec_pkg::MAXF_W;
	localparam int PROD1_W = prec_pkg::PROD1_W;
	localparam int PROD2_W = prec_pkg::PROD2_W;
	localparam int FREQ_W = prec_pkg::FREQ_W;
	localparam int MIN_F_W = prec_pkg::MIN_F_W;
	localparam int D20_W = prec_pkg::DIV20_PROD_W;
	localparam int RELOAD_W = prec_pkg::RELOAD_W;
	localparam int CNT_W = prec_pkg::DIV_CNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PASS = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_CLAMP = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;
	logic [prec_pkg::ACT_W-1:0] act_q;
	logic [SV_W-1:0] v_q;
	logic [prec_pkg::MAG_W-1:0] mag_q;
	logic [PASS_W-1:0] pass_q;
	logic nconv_q;
	logic [PROD1_W-1:0] prod1_q;
	logic [MIN_F_W-1:0] min_f_q;
	logic [FREQ_W-1:0] freq_raw_q;
	logic [MAXF_W-1:0] div_d_q, rem_q;
	logic [RELOAD_W-1:0] quo_q;
	logic [CNT_W-1:0] bit_q;
	logic out_valid_q;
	logic [prec_pkg::M_TDATA_W-1:0] out_data_q;

	logic [SV_W-1:0] nv;
	logic changed;
	logic [D20_W-1:0] d20_prod;
	logic [PROD2_W-1:0] prod2;
	logic [FREQ_W-1:0] f_lo;
	logic [MAXF_W-1:0] f_cl;
	logic [MAXF_W:0] div_t, div_diff;
	logic div_ge;
	logic out_load;

	assign pop_ready = state_q == ST_IDLE;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	always_comb begin
		nv = prec_pkg::rule_pass(v_q);
		changed = nv != v_q;
		d20_prod = D20_W'(cfg.fmax) * D20_W'(prec_pkg::DIV20_MUL);
		prod2 = PROD2_W'(prod1_q) * PROD2_W'(mag_q);
		f_lo = (freq_raw_q < FREQ_W'(min_f_q)) ? FREQ_W'(min_f_q) : freq_raw_q;
		f_cl = (f_lo > FREQ_W'(cfg.fmax)) ? cfg.fmax : f_lo[MAXF_W-1:0];
		div_t = {rem_q, quo_q[RELOAD_W-1]};
		div_ge = div_t >= {1'b0, div_d_q};
		div_diff = div_t - {1'b0, div_d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_PASS;
					end
				end
				ST_PASS: begin
					if (!changed || pass_q == PASS_W'(prec_pkg::MAX_PASSES - 1)) begin
						act_q <= nv[prec_pkg::ACT_LSB +: prec_pkg::ACT_W];
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_CLAMP;
				ST_CLAMP: begin
					if (!v_q[prec_pkg::B_STP] || f_cl == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (bit_q == CNT_W'(RELOAD_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				v_q <= {act_q, pop_data.cond};
				mag_q <= pop_data.mag;
				pass_q <= '0;
			end
			ST_PASS: begin
				v_q <= nv;
				nconv_q <= changed;
				pass_q <= pass_q + 1'b1;
			end
			ST_MUL1: begin
				prod1_q <= PROD1_W'(cfg.fmax) * PROD1_W'(cfg.gain);
				min_f_q <= d20_prod[D20_W-1:prec_pkg::DIV20_SH];
			end
			ST_MUL2: begin
				freq_raw_q <= prod2[PROD2_W-1:prec_pkg::GAIN_SH];
			end
			ST_CLAMP: begin
				div_d_q <= f_cl;
				rem_q <= '0;
				bit_q <= '0;
				quo_q <= (!v_q[prec_pkg::B_STP] || f_cl == '0) ? '0 : prec_pkg::RELOAD_NUM;
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				rem_q <= div_ge ? div_diff[MAXF_W-1:0] : div_t[MAXF_W-1:0];
				quo_q <= {quo_q[RELOAD_W-2:0], div_ge};
				bit_q <= bit_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q <= {2'b00, nconv_q, quo_q[RELOAD_W-1:1], quo_q,
				v_q[prec_pkg::B_DIR], v_q[prec_pkg::B_STP], v_q[prec_pkg::B_PRP],
				v_q[prec_pkg::B_VAC], v_q[prec_pkg::B_DFV], v_q[prec_pkg::B_EXV], v_q};
		end
	end

endmodule
`default_nettype wire

FILE: sv/pressure_rule_engine_control.sv
// pressure rule engine: configuration registers, front end, queue and back end
// path from an accepted request to a valid result: the front stages, the queue,
// the rule passes until the state vector settles or the pass limit, the products and
// clamping, the bit-serial reload divider if the stepper runs, and the output register
// the back end takes a new request only when idle, after the output register is loaded;
// the front stages and the queue keep accepting requests until they fill
// reset: control state and actuator bits cleared, queue empty, ready right after reset
`default_nettype none
module pressure_rule_engine_control (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [prec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [prec_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// static_pressure_raw, ambient_pressure_raw, pitot differential, sensors_ok, zero fill
	input  wire logic [prec_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// state_vector, exhaust_valve_on, diff_valve_on, vacuum_pump_on, pressure_pump_on,
	// stepper_on, stepper_dir_positive, stepper_reload, stepper_compare,
	// not_converged, zero fill
	output logic [prec_pkg::M_TDATA_W-1:0]         m_axis_tdata
);

	prec_pkg::cfg_t cfg_q;
	logic push_valid, push_ready, pop_valid, pop_ready;
	prec_pkg::q_entry_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				prec_pkg::CFG_STATIC_SP: cfg_q.static_sp <= cfg_data[prec_pkg::SSP_W-1:0];
				prec_pkg::CFG_PITOT_SP: cfg_q.pitot_sp <= cfg_data[prec_pkg::PSP_W-1:0];
				prec_pkg::CFG_TOL: cfg_q.tol <= cfg_data[prec_pkg::TOL_W-1:0];
				prec_pkg::CFG_FMAX: cfg_q.fmax <= cfg_data[prec_pkg::MAXF_W-1:0];
				prec_pkg::CFG_GAIN: cfg_q.gain <= cfg_data[prec_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	prec_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	prec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	prec_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_data      (pop_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
`default_nettype wire
